/* rtl/core/sonar_vertical_speed_estimator_unit_assert.svh */
// Assertion macros shared by the sonar vertical speed estimator RTL.
`ifndef SONAR_VERTICAL_SPEED_ESTIMATOR_UNIT_ASSERT_SVH
`define SONAR_VERTICAL_SPEED_ESTIMATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SVSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svse assertion failed");
`define SVSE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svse assertion failed");
`else
`define SVSE_ASSERT_IMP(label, ante, cons)
`define SVSE_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/core/svse_pkg.sv */
// Types and constants of the sonar vertical speed estimator.
package svse_pkg;

    localparam int H_W     = 12;
    localparam int T_W     = 32;
    localparam int SPEED_W = 32;
    localparam int SCALE_W = 24;
    localparam int PROD_W  = H_W + SCALE_W;

    // 10 mm per cm times 1000000 us per s.
    localparam logic [SCALE_W-1:0] SCALE = 24'd10000000;

    typedef struct packed {
        logic [H_W-1:0] height_cm;
        logic [T_W-1:0] time_us;
    } sample_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_mm_s;
        logic                      ready_res;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

/* rtl/core/svse_if.sv */
// Valid/ready channel interfaces for samples and results.
interface svse_sample_if import svse_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface svse_result_if import svse_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/sonar_vertical_speed_estimator_unit.sv */
// Sonar vertical speed estimator: top level with the window walk sequencer.
// Each accepted sample is written into a ring memory of WINDOW (height, time)
// entries, and exactly one result follows it. Until WINDOW samples have been
// taken the result is speed 0 with ready_res clear; it passes from the idle
// state through the result state into the output register. With a full ring
// the sequencer reads the ring from oldest to newest, one entry per read, and
// for each of the WINDOW-1 neighboring pairs forms the height step times
// 10000000 and divides it by the time step in a one-bit-per-cycle divider. The
// sum of the terms is then divided by WINDOW-1 one byte per cycle with a
// reciprocal multiply and saturated to 32 bits. A full-window sample holds the
// input from its transfer until its result sits in the output register. The
// per-pair divider, DIV_W = 36 + clog2(WINDOW) bits wide, takes most of this
// time; a pair with equal capture times skips it. A new sample is taken as
// soon as the previous result sits in the output register, even while that
// result waits.
`include "sonar_vertical_speed_estimator_unit_assert.svh"

module sonar_vertical_speed_estimator_unit import svse_pkg::*; #(
    parameter int WINDOW = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    svse_sample_if.sink   sample,
    svse_result_if.source result
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int DIV_W = PROD_W + $clog2(WINDOW);
    localparam int SUM_W = DIV_W + 1;

    // Mean division: one quotient byte per cycle, the byte taken from a
    // reciprocal multiply that is exact over the partial dividend range.
    localparam int DIG_W      = 8;
    localparam int MEAN_STEPS = (DIV_W + DIG_W - 1) / DIG_W;
    localparam int MEAN_NW    = MEAN_STEPS * DIG_W;
    localparam int MSTEP_W    = $clog2(MEAN_STEPS + 1);
    localparam int MT_W       = IDX_W + DIG_W;
    localparam int MREC_K     = MT_W + IDX_W;
    localparam int MREC_W     = MREC_K + 1;
    localparam int MP_W       = MREC_K + DIG_W;

    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0]   PAIR_LAST = IDX_W'(WINDOW - 2);
    localparam logic [CNT_W-1:0]   FILL_FULL = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]   FILL_LAST = CNT_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0]   MEAN_DEN  = IDX_W'(WINDOW - 1);
    localparam logic [MREC_W-1:0]  MEAN_REC  =
        MREC_W'((2 ** MREC_K + WINDOW - 2) / (WINDOW - 1));
    localparam logic [MEAN_NW-1:0] POS_LIM   = MEAN_NW'(33'h07fffffff);
    localparam logic [MEAN_NW-1:0] NEG_LIM   = MEAN_NW'(33'h080000000);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_RD     = 4'd1;
    localparam logic [ST_W-1:0] ST_CAPT   = 4'd2;
    localparam logic [ST_W-1:0] ST_MUL    = 4'd3;
    localparam logic [ST_W-1:0] ST_DIVS   = 4'd4;
    localparam logic [ST_W-1:0] ST_DIVW   = 4'd5;
    localparam logic [ST_W-1:0] ST_NEXT   = 4'd6;
    localparam logic [ST_W-1:0] ST_MEAN   = 4'd7;
    localparam logic [ST_W-1:0] ST_MEANW  = 4'd8;
    localparam logic [ST_W-1:0] ST_RESULT = 4'd9;
    localparam logic [ST_W-1:0] ST_SAT    = 4'd10;

    logic [ST_W-1:0]         state_reg, state_next;
    logic [IDX_W-1:0]        wslot_reg, wslot_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        pair_reg, pair_next;
    logic                    first_reg, first_next;
    logic                    res_valid_reg, res_valid_next;
    logic [MSTEP_W-1:0]      mstep_reg, mstep_next;

    sample_t                 prev_reg, prev_next;
    logic signed [H_W:0]     dh_reg, dh_next;
    logic [T_W-1:0]          dt_reg, dt_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic                    neg_reg, neg_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [MEAN_NW-1:0]      mnum_reg, mnum_next;
    logic [MEAN_NW-1:0]      mquo_reg, mquo_next;
    logic [IDX_W-1:0]        mrem_reg, mrem_next;
    result_t                 pend_reg, pend_next;
    result_t                 res_data_reg, res_data_next;

    logic                    ram_we;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    sample_t                 ram_rdata;

    logic                    div_start;
    logic [DIV_W-1:0]        div_num;
    logic [T_W-1:0]          div_den;
    logic [DIV_W-1:0]        div_quo;
    div_sts_t                div_sts;

    logic signed [H_W:0]     dh_abs;
    logic signed [SUM_W-1:0] sum_abs;
    logic signed [SUM_W-1:0] quo_ext;

    logic [MT_W-1:0]         mean_t;
    logic [MP_W-1:0]         mean_prod;
    logic [DIG_W-1:0]        mean_qd;
    logic [MT_W-1:0]         mean_rd;

    svse_ring #(
        .DEPTH (WINDOW),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wslot_reg),
        .wdata (sample.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    svse_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .sts   (div_sts)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    assign dh_abs  = dh_reg[H_W] ? -dh_reg : dh_reg;
    assign sum_abs = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign quo_ext = $signed({1'b0, div_quo});

    // The remainder stays below WINDOW-1, so each quotient digit fits in a byte.
    assign mean_t    = {mrem_reg, mnum_reg[MEAN_NW-1 -: DIG_W]};
    assign mean_prod = MP_W'(mean_t) * MP_W'(MEAN_REC);
    assign mean_qd   = mean_prod[MREC_K +: DIG_W];
    assign mean_rd   = mean_t - MT_W'(mean_qd) * MT_W'(MEAN_DEN);

    always_comb
    begin
        state_next     = state_reg;
        wslot_next     = wslot_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        pair_next      = pair_reg;
        first_next     = first_reg;
        res_valid_next = res_valid_reg && !result.ready;
        mstep_next     = mstep_reg;
        prev_next      = prev_reg;
        dh_next        = dh_reg;
        dt_next        = dt_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        sum_next       = sum_reg;
        mnum_next      = mnum_reg;
        mquo_next      = mquo_reg;
        mrem_next      = mrem_reg;
        pend_next      = pend_reg;
        res_data_next  = res_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg;
        div_start      = 1'b0;
        div_num        = DIV_W'(prod_reg);
        div_den        = dt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    ram_we     = 1'b1;
                    wslot_next = (wslot_reg == IDX_LAST) ? '0 : wslot_reg + 1'b1;
                    fill_next  = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
                    if (fill_reg >= FILL_LAST)
                    begin
                        // The slot after the one just written holds the oldest sample.
                        rd_idx_next = wslot_next;
                        pair_next   = '0;
                        first_next  = 1'b1;
                        sum_next    = '0;
                        state_next  = ST_RD;
                    end
                    else
                    begin
                        pend_next.speed_mm_s = '0;
                        pend_next.ready_res  = 1'b0;
                        state_next           = ST_RESULT;
                    end
                end
            end
            ST_RD:
            begin
                ram_re      = 1'b1;
                rd_idx_next = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
                state_next  = ST_CAPT;
            end
            ST_CAPT:
            begin
                prev_next = ram_rdata;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    state_next = ST_RD;
                end
                else
                begin
                    dh_next    = $signed({1'b0, ram_rdata.height_cm})
                               - $signed({1'b0, prev_reg.height_cm});
                    dt_next    = ram_rdata.time_us - prev_reg.time_us;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                neg_next   = dh_reg[H_W];
                prod_next  = PROD_W'(dh_abs[H_W-1:0]) * PROD_W'(SCALE);
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                // Equal capture times contribute nothing to the sum.
                if (dt_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (div_sts.done)
                begin
                    sum_next   = neg_reg ? sum_reg - quo_ext : sum_reg + quo_ext;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (pair_reg == PAIR_LAST)
                begin
                    state_next = ST_MEAN;
                end
                else
                begin
                    pair_next  = pair_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_MEAN:
            begin
                mnum_next  = MEAN_NW'(sum_abs[DIV_W-1:0]);
                mrem_next  = '0;
                mstep_next = MSTEP_W'(MEAN_STEPS);
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_MEANW;
            end
            ST_MEANW:
            begin
                mnum_next  = {mnum_reg[MEAN_NW-DIG_W-1:0], {DIG_W{1'b0}}};
                mquo_next  = {mquo_reg[MEAN_NW-DIG_W-1:0], mean_qd};
                mrem_next  = mean_rd[IDX_W-1:0];
                mstep_next = mstep_reg - 1'b1;
                if (mstep_reg == MSTEP_W'(1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                pend_next.ready_res = 1'b1;
                if (!neg_reg)
                begin
                    pend_next.speed_mm_s = (mquo_reg > POS_LIM) ?
                        SPEED_W'(POS_LIM) : $signed(mquo_reg[SPEED_W-1:0]);
                end
                else
                begin
                    pend_next.speed_mm_s = (mquo_reg > NEG_LIM) ?
                        SPEED_W'(NEG_LIM) : -$signed(mquo_reg[SPEED_W-1:0]);
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wslot_reg     <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            pair_reg      <= '0;
            first_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            mstep_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wslot_reg     <= wslot_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            pair_reg      <= pair_next;
            first_reg     <= first_next;
            res_valid_reg <= res_valid_next;
            mstep_reg     <= mstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        dh_reg       <= dh_next;
        dt_reg       <= dt_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        sum_reg      <= sum_next;
        mnum_reg     <= mnum_next;
        mquo_reg     <= mquo_next;
        mrem_reg     <= mrem_next;
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

    `SVSE_ASSERT_IMP(a_div_start_free, div_start, !div_sts.busy)
    `SVSE_ASSERT_IMP(a_ring_port_excl, ram_we, !ram_re)
    `SVSE_ASSERT_NXT(a_take_leaves_idle, sample.valid && sample.ready, state_reg != ST_IDLE)
    `SVSE_ASSERT_IMP(a_not_ready_zero, result.valid && !result.data.ready_res, result.data.speed_mm_s == '0)

endmodule

/* rtl/core/svse_ring.sv */
// Sample ring memory: one write port, one read port with registered read data.
module svse_ring import svse_pkg::*; #(
    parameter int DEPTH = 30,
    parameter int IDX_W = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  sample_t          wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output sample_t          rdata
);

    sample_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/svse_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
module svse_div import svse_pkg::*; #(
    parameter int DIV_W = 41
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [T_W-1:0]   den,
    output logic [DIV_W-1:0] quo,
    output div_sts_t         sts
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [T_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [T_W-1:0]   den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [T_W:0]     trial;
    logic [T_W:0]     diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[T_W-1:0] : trial[T_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo      = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule
